// ===== sv/i2c_eeprom_byte_master_assert.svh =====
// Assertion macros used by the i2c_eeprom_byte_master result queue.
// No dependencies; include by bare file name inside a module body.
`ifndef I2C_EEPROM_BYTE_MASTER_ASSERT_SVH
`define I2C_EEPROM_BYTE_MASTER_ASSERT_SVH

// Clocked check, disabled while reset is high.
`define I2C_EBM_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define I2C_EBM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/i2c_ebm_pkg.sv =====
// Package for the I2C EEPROM byte master: phase and stage codes, result bundle,
// register indexes and field widths. No dependencies.
`timescale 1ns / 1ps

package i2c_ebm_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned WAIT_W      = 16;
  localparam int unsigned DEV_ADDR_W  = 7;

  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET  = 7'd80;
  localparam logic [WAIT_W-1:0]     WAIT_RESET      = 16'd5600;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITE_WAIT_TICKS = 8'd1;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_ST_SCL     = 5'd1,
    PH_TX_SET     = 5'd2,
    PH_TX_HIGH    = 5'd3,
    PH_TX_LOW     = 5'd4,
    PH_ACK_REL    = 5'd5,
    PH_ACK_HIGH   = 5'd6,
    PH_ACK_SAMPLE = 5'd7,
    PH_RS_SDA     = 5'd8,
    PH_RS_SCLH    = 5'd9,
    PH_RS_SDAL    = 5'd10,
    PH_RS_SCLL    = 5'd11,
    PH_RX_HIGH    = 5'd12,
    PH_RX_SAMPLE  = 5'd13,
    PH_NK_HIGH    = 5'd14,
    PH_NK_LOW     = 5'd15,
    PH_SP_SDA     = 5'd16,
    PH_SP_SCL     = 5'd17,
    PH_SP_SDAH    = 5'd18,
    PH_WAIT       = 5'd19
  } phase_t;

  typedef enum logic [1:0] {
    STG_DEV  = 2'd0,
    STG_ADDR = 2'd1,
    STG_DATA = 2'd2,
    STG_READ = 2'd3
  } stage_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] read_value;
    logic       ack_error;
  } res_t;

endpackage

// ===== sv/i2c_eeprom_byte_master.sv =====
// I2C EEPROM byte master, top level: configuration registers, sequencer, result queue.
// Depends on i2c_ebm_pkg, i2c_ebm_seq and i2c_ebm_outq.
`timescale 1ns / 1ps

// Usage:
//   Each input transfer (func, mem_addr, write_data, sda_in) is one bus tick; func 1
//   starts a byte write, func 2 a byte read, anything else is a plain tick. Commands
//   are taken only when the sequencer is idle.
//   Each input transfer produces exactly one output transfer with the line levels
//   (scl_out, sda_out), busy_res, done_res, read_value and ack_error after that tick.
//   Output: each result waits in the queue until earlier results are taken.
//   Throughput: one tick per cycle while in_ready is high; the sequencer computes each
//   tick combinationally between its state registers and the two-entry result queue.
//   Stall: in_ready stays high while the queue has a free entry, so one result may
//   wait while the next tick is taken; with two results waiting, in_ready drops.
//   Configuration: cfg_index 0 sets device_address, 1 sets write_wait_ticks; other
//   indexes are ignored. cfg_ready is always high; write only while idle.
//   Reset (rst, synchronous): sequencer idle, both lines released high, queue empty,
//   device_address 80, write_wait_ticks 5600.
module i2c_eeprom_byte_master import i2c_ebm_pkg::*; #(
  parameter int unsigned WaitW = WAIT_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             func,
  input  logic [7:0]             mem_addr,
  input  logic [7:0]             write_data,
  input  logic                   sda_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   scl_out,
  output logic                   sda_out,
  output logic                   busy_res,
  output logic                   done_res,
  output logic [7:0]             read_value,
  output logic                   ack_error,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [DEV_ADDR_W-1:0] device_address;
  logic [WaitW-1:0]      write_wait_ticks;
  logic                  step;
  res_t                  step_res;
  res_t                  out_res;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= DEV_ADDR_RESET;
      write_wait_ticks <= WaitW'(WAIT_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS:   device_address   <= cfg_data[DEV_ADDR_W-1:0];
        REG_WRITE_WAIT_TICKS: write_wait_ticks <= WaitW'(cfg_data);
        default: ;
      endcase
    end
  end

  i2c_ebm_seq #(
    .WaitW(WaitW)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .func             (func),
    .mem_addr         (mem_addr),
    .write_data       (write_data),
    .sda_in           (sda_in),
    .device_address   (device_address),
    .write_wait_ticks (write_wait_ticks),
    .res              (step_res)
  );

  i2c_ebm_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_res   (step_res),
    .push_ready (in_ready),
    .pop_valid  (out_valid),
    .pop        (out_ready),
    .pop_res    (out_res)
  );

  assign scl_out    = out_res.scl;
  assign sda_out    = out_res.sda;
  assign busy_res   = out_res.busy;
  assign done_res   = out_res.done;
  assign read_value = out_res.read_value;
  assign ack_error  = out_res.ack_error;

endmodule

// ===== sv/i2c_ebm_seq.sv =====
// Bus sequencer: phase register and one tick of next-state logic per transfer.
// Depends on i2c_ebm_pkg.
`timescale 1ns / 1ps

module i2c_ebm_seq import i2c_ebm_pkg::*; #(
  parameter int unsigned WaitW = WAIT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [1:0]            func,
  input  logic [7:0]            mem_addr,
  input  logic [7:0]            write_data,
  input  logic                  sda_in,
  input  logic [DEV_ADDR_W-1:0] device_address,
  input  logic [WaitW-1:0]      write_wait_ticks,
  output res_t                  res
);

  phase_t           phase, phase_next;
  stage_t           byte_stage, byte_stage_next;
  logic [3:0]       bit_counter, bit_counter_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [WaitW-1:0] wait_counter, wait_counter_next;
  logic             is_read, is_read_next;
  logic [7:0]       held_address, held_address_next;
  logic [7:0]       held_data, held_data_next;
  logic [7:0]       received_byte, received_byte_next;
  logic             error_flag, error_flag_next;
  logic             line_scl, line_scl_next;
  logic             line_sda, line_sda_next;
  logic             done;
  logic [3:0]       bit_inc;
  logic [7:0]       rx_byte;

  assign bit_inc = bit_counter + 4'd1;
  assign rx_byte = {shift_byte[6:0], sda_in};

  // next state
  always_comb begin
    phase_next         = phase;
    byte_stage_next    = byte_stage;
    bit_counter_next   = bit_counter;
    shift_byte_next    = shift_byte;
    wait_counter_next  = wait_counter;
    is_read_next       = is_read;
    held_address_next  = held_address;
    held_data_next     = held_data;
    received_byte_next = received_byte;
    error_flag_next    = error_flag;
    line_scl_next      = line_scl;
    line_sda_next      = line_sda;
    done               = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (func == FUNC_WRITE || func == FUNC_READ) begin
          held_address_next = mem_addr;
          held_data_next    = write_data;
          is_read_next      = (func == FUNC_READ);
          error_flag_next   = 1'b0;
          byte_stage_next   = STG_DEV;
          bit_counter_next  = 4'd0;
          shift_byte_next   = {device_address, 1'b0};
          line_sda_next     = 1'b0;
          phase_next        = PH_ST_SCL;
        end
      end
      PH_ST_SCL: begin
        line_scl_next = 1'b0;
        phase_next    = PH_TX_SET;
      end
      PH_TX_SET: begin
        line_sda_next = shift_byte[7];
        phase_next    = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        line_scl_next = 1'b1;
        phase_next    = PH_TX_LOW;
      end
      PH_TX_LOW: begin
        line_scl_next   = 1'b0;
        shift_byte_next = {shift_byte[6:0], 1'b0};
        if (bit_inc[3]) begin
          bit_counter_next = 4'd0;
          phase_next       = PH_ACK_REL;
        end else begin
          bit_counter_next = bit_inc;
          phase_next       = PH_TX_SET;
        end
      end
      PH_ACK_REL: begin
        line_sda_next = 1'b1;
        phase_next    = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        line_scl_next = 1'b1;
        phase_next    = PH_ACK_SAMPLE;
      end
      PH_ACK_SAMPLE: begin
        line_scl_next = 1'b0;
        if (sda_in) begin
          error_flag_next = 1'b1;
          phase_next      = PH_SP_SDA;
        end else begin
          case (byte_stage)
            STG_DEV: begin
              byte_stage_next = STG_ADDR;
              shift_byte_next = held_address;
              phase_next      = PH_TX_SET;
            end
            STG_ADDR: begin
              if (is_read) begin
                byte_stage_next = STG_READ;
                phase_next      = PH_RS_SDA;
              end else begin
                byte_stage_next = STG_DATA;
                shift_byte_next = held_data;
                phase_next      = PH_TX_SET;
              end
            end
            STG_DATA: begin
              phase_next = PH_SP_SDA;
            end
            default: begin
              bit_counter_next = 4'd0;
              shift_byte_next  = 8'd0;
              phase_next       = PH_RX_HIGH;
            end
          endcase
        end
      end
      PH_RS_SDA: begin
        line_sda_next = 1'b1;
        phase_next    = PH_RS_SCLH;
      end
      PH_RS_SCLH: begin
        line_scl_next = 1'b1;
        phase_next    = PH_RS_SDAL;
      end
      PH_RS_SDAL: begin
        line_sda_next = 1'b0;
        phase_next    = PH_RS_SCLL;
      end
      PH_RS_SCLL: begin
        line_scl_next    = 1'b0;
        shift_byte_next  = {device_address, 1'b1};
        bit_counter_next = 4'd0;
        phase_next       = PH_TX_SET;
      end
      PH_RX_HIGH: begin
        line_scl_next = 1'b1;
        phase_next    = PH_RX_SAMPLE;
      end
      PH_RX_SAMPLE: begin
        line_scl_next   = 1'b0;
        shift_byte_next = rx_byte;
        if (bit_inc[3]) begin
          bit_counter_next   = 4'd0;
          received_byte_next = rx_byte;
          phase_next         = PH_NK_HIGH;
        end else begin
          bit_counter_next = bit_inc;
          phase_next       = PH_RX_HIGH;
        end
      end
      PH_NK_HIGH: begin
        line_scl_next = 1'b1;
        phase_next    = PH_NK_LOW;
      end
      PH_NK_LOW: begin
        line_scl_next = 1'b0;
        phase_next    = PH_SP_SDA;
      end
      PH_SP_SDA: begin
        line_sda_next = 1'b0;
        phase_next    = PH_SP_SCL;
      end
      PH_SP_SCL: begin
        line_scl_next = 1'b1;
        phase_next    = PH_SP_SDAH;
      end
      PH_SP_SDAH: begin
        line_sda_next = 1'b1;
        if (!is_read && !error_flag) begin
          wait_counter_next = write_wait_ticks;
          phase_next        = PH_WAIT;
        end else begin
          done       = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (wait_counter == '0) begin
          done       = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          wait_counter_next = wait_counter - WaitW'(1);
        end
      end
      default: begin
        line_scl_next = 1'b1;
        line_sda_next = 1'b1;
        phase_next    = PH_IDLE;
      end
    endcase
  end

  // result of this tick
  always_comb begin
    res.scl        = line_scl_next;
    res.sda        = line_sda_next;
    res.busy       = (phase_next != PH_IDLE);
    res.done       = done;
    res.read_value = received_byte_next;
    res.ack_error  = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_stage    <= STG_DEV;
      bit_counter   <= 4'd0;
      shift_byte    <= 8'd0;
      wait_counter  <= '0;
      is_read       <= 1'b0;
      held_address  <= 8'd0;
      held_data     <= 8'd0;
      received_byte <= 8'd0;
      error_flag    <= 1'b0;
      line_scl      <= 1'b1;
      line_sda      <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      byte_stage    <= byte_stage_next;
      bit_counter   <= bit_counter_next;
      shift_byte    <= shift_byte_next;
      wait_counter  <= wait_counter_next;
      is_read       <= is_read_next;
      held_address  <= held_address_next;
      held_data     <= held_data_next;
      received_byte <= received_byte_next;
      error_flag    <= error_flag_next;
      line_scl      <= line_scl_next;
      line_sda      <= line_sda_next;
    end
  end

endmodule

// ===== sv/i2c_ebm_outq.sv =====
// Two-entry result queue between the sequencer and the output channel.
// Depends on i2c_ebm_pkg and i2c_eeprom_byte_master_assert.svh.
`timescale 1ns / 1ps

module i2c_ebm_outq import i2c_ebm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  output logic push_ready,
  output logic pop_valid,
  input  logic pop,
  output res_t pop_res
);

  `include "i2c_eeprom_byte_master_assert.svh"

  res_t       slot [2];
  logic       wr_ptr, wr_ptr_next;
  logic       rd_ptr, rd_ptr_next;
  logic [1:0] count, count_next;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_res    = slot[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_next = wr_ptr ^ do_push;
    rd_ptr_next = rd_ptr ^ do_pop;
    count_next  = count + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_res;
    end
  end

  `I2C_EBM_ASSERT_ALWAYS(a_count_bound, clk, rst || count != 2'd3,
    "result queue count out of range")
  `I2C_EBM_ASSERT(a_ptr_count, clk, rst, (count == 2'd1) == (wr_ptr != rd_ptr),
    "queue pointers disagree with count")
  `I2C_EBM_ASSERT(a_push_grow, clk, rst,
    (do_push && !do_pop) |=> count == $past(count) + 2'd1, "push lost in result queue")

endmodule
